// ===== rtl/core/htok_pkg.sv =====
// ----------------------------------------------------------------------------
// htok_pkg
// Shared types, field codes and match-text lookups for the request tokenizer.
// ----------------------------------------------------------------------------
package htok_pkg;

  // field classes
  localparam logic [2:0] CLS_METHOD = 3'd0;
  localparam logic [2:0] CLS_PATH   = 3'd1;
  localparam logic [2:0] CLS_QUERY  = 3'd2;
  localparam logic [2:0] CLS_PROTO  = 3'd3;
  localparam logic [2:0] CLS_HNAME  = 3'd4;
  localparam logic [2:0] CLS_HVALUE = 3'd5;
  localparam logic [2:0] CLS_BODY   = 3'd6;
  localparam logic [2:0] CLS_SEP    = 3'd7;

  // error codes
  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_METHOD = 3'd1;
  localparam logic [2:0] ERR_URL    = 3'd2;
  localparam logic [2:0] ERR_PROTO  = 3'd3;
  localparam logic [2:0] ERR_HEADER = 3'd4;
  localparam logic [2:0] ERR_COUNT  = 3'd5;

  // extension status
  localparam logic [1:0] EXT_UNKNOWN = 2'd0;
  localparam logic [1:0] EXT_DIR     = 2'd1;
  localparam logic [1:0] EXT_NONE    = 2'd2;
  localparam logic [1:0] EXT_PRESENT = 2'd3;

  // method and protocol codes
  localparam logic       METH_GET  = 1'b0;
  localparam logic       METH_POST = 1'b1;
  localparam logic [1:0] PROT_11   = 2'd0;
  localparam logic [1:0] PROT_2    = 2'd1;
  localparam logic [1:0] PROT_3    = 2'd2;

  // text lengths
  localparam logic [3:0] LEN_GET    = 4'd3;
  localparam logic [3:0] LEN_POST   = 4'd4;
  localparam logic [3:0] LEN_HTTP11 = 4'd8;
  localparam logic [3:0] LEN_HTTP2X = 4'd6;

  // special bytes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_QMARK = 8'h3F;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] field_class;
    logic       field_first;
    logic       method_code;
    logic [1:0] proto_code;
    logic [7:0] header_index;
    logic [1:0] ext_status;
    logic [7:0] ext_length;
    logic [2:0] error_code;
    logic       request_done;
  } htok_result_t;

  // character of GET (sel 0) or POST (sel 1) at a position
  function automatic logic [7:0] meth_char(input logic sel, input logic [3:0] pos);
    logic [7:0] c;
    c = CH_NUL;
    case (pos)
      4'd0:    c = sel ? 8'h50 : 8'h47;  // P / G
      4'd1:    c = sel ? 8'h4F : 8'h45;  // O / E
      4'd2:    c = sel ? 8'h53 : 8'h54;  // S / T
      4'd3:    c = sel ? 8'h54 : CH_NUL; // T
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  // character of HTTP/1.1, HTTP/2 or HTTP/3 at a position
  function automatic logic [7:0] prot_char(input logic [1:0] sel, input logic [3:0] pos);
    logic [7:0] c;
    c = CH_NUL;
    case (pos)
      4'd0:    c = 8'h48;
      4'd1:    c = 8'h54;
      4'd2:    c = 8'h54;
      4'd3:    c = 8'h50;
      4'd4:    c = CH_SLASH;
      4'd5: begin
        case (sel)
          PROT_11: c = 8'h31;
          PROT_2:  c = 8'h32;
          PROT_3:  c = 8'h33;
          default: c = CH_NUL;
        endcase
      end
      4'd6:    c = CH_DOT;
      4'd7:    c = 8'h31;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/htok_parser.sv =====
// ----------------------------------------------------------------------------
// htok_parser
// Parse state of one request and the per-byte tagging logic; state moves on
// each step strobe.
// ----------------------------------------------------------------------------
module htok_parser import htok_pkg::*; #(
  parameter int EXT_COUNT_BITS    = 8,
  parameter int HEADER_COUNT_BITS = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic [7:0]   in_byte,
  input  logic         in_last,
  input  logic [7:0]   max_lines,
  output htok_result_t result
);

  localparam int EXT_W = (EXT_COUNT_BITS > 8) ? EXT_COUNT_BITS : 8;
  localparam int HDR_W = (HEADER_COUNT_BITS > 8) ? HEADER_COUNT_BITS : 8;
  localparam logic [EXT_COUNT_BITS-1:0]    EXT_MAX = {EXT_COUNT_BITS{1'b1}};
  localparam logic [HEADER_COUNT_BITS-1:0] HDR_MAX = {HEADER_COUNT_BITS{1'b1}};

  localparam logic [1:0] COL_NAME  = 2'd0;
  localparam logic [1:0] COL_SEEN  = 2'd1;
  localparam logic [1:0] COL_VALUE = 2'd2;

  localparam logic [1:0] CR_INLINE = 2'd0;
  localparam logic [1:0] CR_LINE   = 2'd1;
  localparam logic [1:0] CR_START  = 2'd2;
  localparam logic [1:0] CR_BLANK  = 2'd3;

  typedef enum logic [6:0] {
    PH_METHOD = 7'b0000001,
    PH_PATH   = 7'b0000010,
    PH_QUERY  = 7'b0000100,
    PH_PROTO  = 7'b0001000,
    PH_HEADER = 7'b0010000,
    PH_BODY   = 7'b0100000,
    PH_DONE   = 7'b1000000
  } phase_t;

  phase_t                       phase, phase_next;
  logic [3:0]                   match_pos, match_pos_next;
  logic [2:0]                   cand_mask, cand_mask_next;
  logic                         method_reg, method_reg_next;
  logic [1:0]                   proto_reg, proto_reg_next;
  logic                         dot_seen, dot_seen_next;
  logic                         last_slash, last_slash_next;
  logic [EXT_COUNT_BITS-1:0]    ext_count, ext_count_next;
  logic [HEADER_COUNT_BITS-1:0] header_count, header_count_next;
  logic [1:0]                   colon_state, colon_state_next;
  logic [1:0]                   crlf_track, crlf_track_next;
  logic [2:0]                   error_reg, error_reg_next;

  logic [3:0]                   bump_pos;
  logic                         bump_first;
  logic [HEADER_COUNT_BITS-1:0] hdr_inc;
  logic [2:0]                   cls;
  logic                         first;
  logic [2:0]                   err;
  logic [2:0]                   nm;
  logic                         hit_get, hit_post;
  logic                         hit_p11, hit_p2, hit_p3;
  logic [HDR_W-1:0]             hdr_wide;
  logic [EXT_W-1:0]             ext_wide;
  logic [1:0]                   ext_st;
  logic [7:0]                   ext_len;

  assign bump_first = (match_pos == 4'd0);
  assign bump_pos   = (match_pos == 4'hF) ? match_pos : match_pos + 4'd1;
  assign hdr_inc    = (header_count == HDR_MAX) ? header_count
                                                : header_count + 1'b1;

  assign hit_get  = cand_mask[0] && (match_pos == LEN_GET)  && (in_byte == CH_SPACE);
  assign hit_post = cand_mask[1] && (match_pos == LEN_POST) && (in_byte == CH_SPACE);
  assign hit_p11  = cand_mask[0] && (match_pos == LEN_HTTP11);
  assign hit_p2   = cand_mask[1] && (match_pos == LEN_HTTP2X);
  assign hit_p3   = cand_mask[2] && (match_pos == LEN_HTTP2X);

  always_comb begin
    phase_next        = phase;
    match_pos_next    = match_pos;
    cand_mask_next    = cand_mask;
    method_reg_next   = method_reg;
    proto_reg_next    = proto_reg;
    dot_seen_next     = dot_seen;
    last_slash_next   = last_slash;
    ext_count_next    = ext_count;
    header_count_next = header_count;
    colon_state_next  = colon_state;
    crlf_track_next   = crlf_track;
    error_reg_next    = error_reg;
    cls   = CLS_SEP;
    first = 1'b0;
    err   = ERR_NONE;
    nm    = 3'b000;

    case (phase)
      PH_METHOD: begin
        nm[0] = cand_mask[0] && (match_pos < LEN_GET)
                && (in_byte == meth_char(METH_GET, match_pos));
        nm[1] = cand_mask[1] && (match_pos < LEN_POST)
                && (in_byte == meth_char(METH_POST, match_pos));
        if (hit_get || hit_post) begin
          method_reg_next = hit_post;
          phase_next      = PH_PATH;
          match_pos_next  = 4'd0;
        end else if (nm[1:0] == 2'b00) begin
          err = ERR_METHOD;
        end else begin
          cls            = CLS_METHOD;
          cand_mask_next = {1'b0, nm[1:0]};
          first          = bump_first;
          match_pos_next = bump_pos;
        end
      end
      PH_PATH: begin
        if (in_byte == CH_SPACE) begin
          phase_next      = PH_PROTO;
          match_pos_next  = 4'd0;
          cand_mask_next  = 3'b111;
          crlf_track_next = CR_INLINE;
        end else if (in_byte == CH_QMARK) begin
          phase_next     = PH_QUERY;
          match_pos_next = 4'd0;
        end else if (in_byte == CH_NUL) begin
          err = ERR_URL;
        end else begin
          cls            = CLS_PATH;
          first          = bump_first;
          match_pos_next = bump_pos;
          if (in_byte == CH_SLASH) begin
            last_slash_next = 1'b1;
            dot_seen_next   = 1'b0;
            ext_count_next  = '0;
          end else if (in_byte == CH_DOT) begin
            last_slash_next = 1'b0;
            dot_seen_next   = 1'b1;
            ext_count_next  = '0;
          end else begin
            last_slash_next = 1'b0;
            if (ext_count != EXT_MAX) ext_count_next = ext_count + 1'b1;
          end
        end
      end
      PH_QUERY: begin
        if (in_byte == CH_SPACE) begin
          phase_next      = PH_PROTO;
          match_pos_next  = 4'd0;
          cand_mask_next  = 3'b111;
          crlf_track_next = CR_INLINE;
        end else if (in_byte == CH_NUL) begin
          err = ERR_URL;
        end else begin
          cls            = CLS_QUERY;
          first          = bump_first;
          match_pos_next = bump_pos;
        end
      end
      PH_PROTO: begin
        nm[0] = cand_mask[0] && (match_pos < LEN_HTTP11)
                && (in_byte == prot_char(PROT_11, match_pos));
        nm[1] = cand_mask[1] && (match_pos < LEN_HTTP2X)
                && (in_byte == prot_char(PROT_2, match_pos));
        nm[2] = cand_mask[2] && (match_pos < LEN_HTTP2X)
                && (in_byte == prot_char(PROT_3, match_pos));
        if (crlf_track == CR_LINE) begin
          if (in_byte == CH_LF) begin
            phase_next       = PH_HEADER;
            crlf_track_next  = CR_START;
            colon_state_next = COL_NAME;
            match_pos_next   = 4'd0;
          end else begin
            err = ERR_PROTO;
          end
        end else if ((in_byte == CH_CR) && (hit_p11 || hit_p2 || hit_p3)) begin
          proto_reg_next  = hit_p3 ? PROT_3 : (hit_p2 ? PROT_2 : PROT_11);
          crlf_track_next = CR_LINE;
        end else if (nm == 3'b000) begin
          err = ERR_PROTO;
        end else begin
          cls            = CLS_PROTO;
          cand_mask_next = nm;
          first          = bump_first;
          match_pos_next = bump_pos;
        end
      end
      PH_HEADER: begin
        if (crlf_track == CR_LINE) begin
          if (in_byte == CH_LF) begin
            header_count_next = hdr_inc;
            if (HDR_W'(hdr_inc) > HDR_W'(max_lines)) begin
              err = ERR_COUNT;
            end else begin
              crlf_track_next  = CR_START;
              colon_state_next = COL_NAME;
              match_pos_next   = 4'd0;
            end
          end else begin
            err = ERR_HEADER;
          end
        end else if (crlf_track == CR_BLANK) begin
          if (in_byte == CH_LF) begin
            phase_next     = PH_BODY;
            match_pos_next = 4'd0;
          end else begin
            err = ERR_HEADER;
          end
        end else if (colon_state == COL_SEEN) begin
          if (in_byte == CH_SPACE) begin
            colon_state_next = COL_VALUE;
            match_pos_next   = 4'd0;
          end else begin
            err = ERR_HEADER;
          end
        end else if (colon_state == COL_VALUE) begin
          if (in_byte == CH_CR) begin
            crlf_track_next = CR_LINE;
          end else if (in_byte == CH_NUL) begin
            err = ERR_HEADER;
          end else begin
            cls            = CLS_HVALUE;
            first          = bump_first;
            match_pos_next = bump_pos;
          end
        end else if ((crlf_track == CR_START) && (in_byte == CH_CR)) begin
          // blank line: only legal after at least one header line
          if (header_count == '0) err = ERR_HEADER;
          else crlf_track_next = CR_BLANK;
        end else if (in_byte == CH_COLON) begin
          colon_state_next = COL_SEEN;
          crlf_track_next  = CR_INLINE;
        end else if ((in_byte == CH_NUL) || (in_byte == CH_CR) || (in_byte == CH_LF)) begin
          err = ERR_HEADER;
        end else begin
          cls             = CLS_HNAME;
          crlf_track_next = CR_INLINE;
          first           = bump_first;
          match_pos_next  = bump_pos;
        end
      end
      PH_BODY: begin
        cls            = CLS_BODY;
        first          = bump_first;
        match_pos_next = bump_pos;
      end
      default: begin
      end
    endcase

    if (err != ERR_NONE) begin
      error_reg_next = err;
      phase_next     = PH_DONE;
      cls            = CLS_SEP;
      first          = 1'b0;
    end

    // request cut short before the body
    if (in_last && (phase_next != PH_BODY) && (phase_next != PH_DONE)) begin
      case (phase_next)
        PH_METHOD:          error_reg_next = ERR_METHOD;
        PH_PATH, PH_QUERY:  error_reg_next = ERR_URL;
        PH_PROTO:           error_reg_next = ERR_PROTO;
        default:            error_reg_next = ERR_HEADER;
      endcase
      phase_next = PH_DONE;
    end
  end

  // extension report, from the state after this byte
  always_comb begin
    ext_wide = EXT_W'(ext_count_next);
    ext_st   = EXT_UNKNOWN;
    ext_len  = 8'd0;
    if ((phase_next == PH_QUERY) || (phase_next == PH_PROTO) || (phase_next == PH_HEADER)
        || (phase_next == PH_BODY)
        || ((phase_next == PH_DONE) && (error_reg_next >= ERR_PROTO))) begin
      if (last_slash_next) begin
        ext_st = EXT_DIR;
      end else if (dot_seen_next) begin
        ext_st  = EXT_PRESENT;
        ext_len = (ext_wide > EXT_W'(8'hFF)) ? 8'hFF : ext_wide[7:0];
      end else begin
        ext_st = EXT_NONE;
      end
    end
  end

  assign hdr_wide = HDR_W'(header_count);

  always_comb begin
    result.out_byte     = in_byte;
    result.field_class  = cls;
    result.field_first  = first;
    result.method_code  = method_reg_next;
    result.proto_code   = proto_reg_next;
    result.header_index = (hdr_wide > HDR_W'(8'hFF)) ? 8'hFF : hdr_wide[7:0];
    result.ext_status   = ext_st;
    result.ext_length   = ext_len;
    result.error_code   = error_reg_next;
    result.request_done = (phase_next == PH_DONE) || in_last;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && in_last)) begin
      phase        <= PH_METHOD;
      match_pos    <= 4'd0;
      cand_mask    <= 3'b111;
      method_reg   <= 1'b0;
      proto_reg    <= 2'd0;
      dot_seen     <= 1'b0;
      last_slash   <= 1'b0;
      ext_count    <= '0;
      header_count <= '0;
      colon_state  <= COL_NAME;
      crlf_track   <= CR_INLINE;
      error_reg    <= ERR_NONE;
    end else if (step) begin
      phase        <= phase_next;
      match_pos    <= match_pos_next;
      cand_mask    <= cand_mask_next;
      method_reg   <= method_reg_next;
      proto_reg    <= proto_reg_next;
      dot_seen     <= dot_seen_next;
      last_slash   <= last_slash_next;
      ext_count    <= ext_count_next;
      header_count <= header_count_next;
      colon_state  <= colon_state_next;
      crlf_track   <= crlf_track_next;
      error_reg    <= error_reg_next;
    end
  end

endmodule

// ===== rtl/core/http_request_tokenizer.sv =====
// ----------------------------------------------------------------------------
// http_request_tokenizer
// Tags each byte of an HTTP/1 request with its field and reports method,
// protocol, header index, path extension and errors.
// ----------------------------------------------------------------------------
//  channel   dir  width  contents
//  s_axis    in   8      request byte, tlast marks the final byte
//  m_axis    out  32     tagged byte and status, tuser class/first, tlast done
//  cfg       in   8      max_header_lines
//
//  one byte per clock unless m_axis stalls; m_axis_tvalid rises after the input
//  transfer (input register, then result register after one pass of the parser)
//  the input stays ready while a result waits, until both registers are full
//  rst is synchronous; it clears the parse state and sets max_header_lines
//  to 64; the parse state also restarts after every final byte
// ----------------------------------------------------------------------------
module http_request_tokenizer import htok_pkg::*; #(
  parameter int EXT_COUNT_BITS    = 8,
  parameter int HEADER_COUNT_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] req_byte
  input  logic        s_axis_tlast,   // end_of_request
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [8] method_code,
                                      // [10:9] proto_code, [18:11] header_index,
                                      // [20:19] ext_status, [28:21] ext_length,
                                      // [31:29] error_code
  output logic [3:0]  m_axis_tuser,   // [2:0] field_class, [3] field_first
  output logic        m_axis_tlast,   // request_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic         in_valid;
  logic [7:0]   in_byte;
  logic         in_last;
  logic         out_valid;
  htok_result_t out_reg;
  htok_result_t result;
  logic         advance;
  logic [7:0]   max_lines;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_lines <= 8'd64;
    end else if (cfg_valid && cfg_ready) begin
      max_lines <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  htok_parser #(
    .EXT_COUNT_BITS    (EXT_COUNT_BITS),
    .HEADER_COUNT_BITS (HEADER_COUNT_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .max_lines (max_lines),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_reg.error_code, out_reg.ext_length, out_reg.ext_status,
                          out_reg.header_index, out_reg.proto_code, out_reg.method_code,
                          out_reg.out_byte};
  assign m_axis_tuser  = {out_reg.field_first, out_reg.field_class};
  assign m_axis_tlast  = out_reg.request_done;

`ifndef SYNTHESIS
  // any error ends the request
  a_err_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_reg.error_code != ERR_NONE) |-> out_reg.request_done)
    else $error("error reported without request_done");

  // the first-byte flag never sits on a separator
  a_first_cls: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_reg.field_first |-> (out_reg.field_class != CLS_SEP))
    else $error("field_first on separator byte");

  // extension length only with an extension present
  a_ext_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_reg.ext_status != EXT_PRESENT) |-> (out_reg.ext_length == 8'd0))
    else $error("ext_length without extension");

  // header and body bytes come after the path has ended
  a_ext_known: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((out_reg.field_class == CLS_HNAME) || (out_reg.field_class == CLS_BODY))
    |-> (out_reg.ext_status != EXT_UNKNOWN))
    else $error("extension unknown after path");

  // a transfer into the parser loads the result register
  a_load: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("parsed byte lost");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams HTTP request bytes through http_request_tokenizer and checks every
// tagged byte against a cycle-free predictor of the tokenizer, across several
// header-limit settings and sender/receiver stall patterns.
// ----------------------------------------------------------------------------
module testbench;
  import htok_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  // line tracking inside the header block
  localparam logic [1:0] LINE_MID      = 2'd0;
  localparam logic [1:0] LINE_CR       = 2'd1;
  localparam logic [1:0] LINE_START    = 2'd2;
  localparam logic [1:0] LINE_BLANK_CR = 2'd3;
  // where a header line stands with respect to its ': '
  localparam logic [1:0] COLON_NONE  = 2'd0;
  localparam logic [1:0] COLON_SEEN  = 2'd1;
  localparam logic [1:0] COLON_VALUE = 2'd2;

  typedef enum logic [6:0] {
    P_METHOD = 7'b0000001,
    P_PATH   = 7'b0000010,
    P_QUERY  = 7'b0000100,
    P_PROTO  = 7'b0001000,
    P_HEADER = 7'b0010000,
    P_BODY   = 7'b0100000,
    P_FAILED = 7'b1000000
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] field_class;
    logic       field_first;
    logic       method_code;
    logic [1:0] proto_code;
    logic [7:0] header_index;
    logic [1:0] ext_status;
    logic [7:0] ext_length;
    logic [2:0] error_code;
    logic       request_done;
  } tag_result_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } req_item_t;

  string method_names[2] = '{"GET", "POST"};
  string proto_names[3]  = '{"HTTP/1.1", "HTTP/2", "HTTP/3"};

  class tag_scoreboard;
    tag_result_t  expected_tags[$];
    logic [7:0]   max_lines;
    parse_phase_t ph;
    logic [3:0]   pos;
    logic [2:0]   cand;
    logic         meth;
    logic [1:0]   prot;
    logic         dot_seen;
    logic         slash_last;
    logic [7:0]   ext_cnt;
    logic [7:0]   hdr_cnt;
    logic [1:0]   colon_st;
    logic [1:0]   line_st;
    logic [2:0]   err;
    int           failures;
    int           results;

    function new();
      max_lines = 8'd64;
      failures  = 0;
      results   = 0;
      restart();
    endfunction

    function void restart();
      ph         = P_METHOD;
      pos        = 4'd0;
      cand       = 3'b111;
      meth       = METH_GET;
      prot       = PROT_11;
      dot_seen   = 1'b0;
      slash_last = 1'b0;
      ext_cnt    = 8'd0;
      hdr_cnt    = 8'd0;
      colon_st   = COLON_NONE;
      line_st    = LINE_MID;
      err        = ERR_NONE;
    endfunction

    // first byte of a field when the count is still zero; count saturates at 15
    function logic bump();
      logic f;
      f = (pos == 4'd0);
      if (pos != 4'd15) pos++;
      return f;
    endfunction

    function void enter_proto();
      ph      = P_PROTO;
      pos     = 4'd0;
      cand    = 3'b111;
      line_st = LINE_MID;
    endfunction

    function void note_input(logic [7:0] b, logic last);
      tag_result_t r;
      logic [2:0]  cls;
      logic        first;
      logic [2:0]  fail;
      logic [2:0]  nm;
      logic [7:0]  hidx;
      int          hit;
      cls   = CLS_SEP;
      first = 1'b0;
      fail  = ERR_NONE;
      nm    = 3'b000;
      hit   = -1;
      hidx  = hdr_cnt;
      r     = '0;
      case (ph)
        P_METHOD: begin
          for (int i = 0; i < 2; i++) begin
            if (cand[i]) begin
              if (pos == method_names[i].len()) begin
                if (b == CH_SPACE) hit = i;
              end else if (pos < method_names[i].len() && b == method_names[i][pos]) begin
                nm[i] = 1'b1;
              end
            end
          end
          if (hit >= 0) begin
            meth = 1'(hit);
            ph   = P_PATH;
            pos  = 4'd0;
          end else if (nm == 3'b000) begin
            fail = ERR_METHOD;
          end else begin
            cls   = CLS_METHOD;
            cand  = nm;
            first = bump();
          end
        end
        P_PATH: begin
          if (b == CH_SPACE) begin
            enter_proto();
          end else if (b == CH_QMARK) begin
            ph  = P_QUERY;
            pos = 4'd0;
          end else if (b == CH_NUL) begin
            fail = ERR_URL;
          end else begin
            cls   = CLS_PATH;
            first = bump();
            if (b == CH_SLASH) begin
              slash_last = 1'b1;
              dot_seen   = 1'b0;
              ext_cnt    = 8'd0;
            end else if (b == CH_DOT) begin
              slash_last = 1'b0;
              dot_seen   = 1'b1;
              ext_cnt    = 8'd0;
            end else begin
              slash_last = 1'b0;
              if (ext_cnt != 8'hFF) ext_cnt++;
            end
          end
        end
        P_QUERY: begin
          if (b == CH_SPACE) begin
            enter_proto();
          end else if (b == CH_NUL) begin
            fail = ERR_URL;
          end else begin
            cls   = CLS_QUERY;
            first = bump();
          end
        end
        P_PROTO: begin
          if (line_st == LINE_CR) begin
            if (b == CH_LF) begin
              ph       = P_HEADER;
              line_st  = LINE_START;
              colon_st = COLON_NONE;
              pos      = 4'd0;
            end else begin
              fail = ERR_PROTO;
            end
          end else begin
            if (b == CH_CR) begin
              for (int i = 0; i < 3; i++)
                if (cand[i] && pos == proto_names[i].len()) hit = i;
            end
            if (hit >= 0) begin
              prot    = 2'(hit);
              line_st = LINE_CR;
            end else begin
              for (int i = 0; i < 3; i++)
                if (cand[i] && pos < proto_names[i].len() && b == proto_names[i][pos])
                  nm[i] = 1'b1;
              if (nm == 3'b000) begin
                fail = ERR_PROTO;
              end else begin
                cls   = CLS_PROTO;
                cand  = nm;
                first = bump();
              end
            end
          end
        end
        P_HEADER: begin
          if (line_st == LINE_CR) begin
            if (b == CH_LF) begin
              if (hdr_cnt != 8'hFF) hdr_cnt++;
              if (hdr_cnt > max_lines) begin
                fail = ERR_COUNT;
              end else begin
                line_st  = LINE_START;
                colon_st = COLON_NONE;
                pos      = 4'd0;
              end
            end else begin
              fail = ERR_HEADER;
            end
          end else if (line_st == LINE_BLANK_CR) begin
            if (b == CH_LF) begin
              ph  = P_BODY;
              pos = 4'd0;
            end else begin
              fail = ERR_HEADER;
            end
          end else if (colon_st == COLON_SEEN) begin
            if (b == CH_SPACE) begin
              colon_st = COLON_VALUE;
              pos      = 4'd0;
            end else begin
              fail = ERR_HEADER;
            end
          end else if (colon_st == COLON_VALUE) begin
            if (b == CH_CR) begin
              line_st = LINE_CR;
            end else if (b == CH_NUL) begin
              fail = ERR_HEADER;
            end else begin
              cls   = CLS_HVALUE;
              first = bump();
            end
          end else if (line_st == LINE_START && b == CH_CR) begin
            // blank line ends the headers, but only after at least one line
            if (hdr_cnt == 8'd0) fail = ERR_HEADER;
            else line_st = LINE_BLANK_CR;
          end else if (b == CH_COLON) begin
            colon_st = COLON_SEEN;
            line_st  = LINE_MID;
          end else if (b == CH_NUL || b == CH_CR || b == CH_LF) begin
            fail = ERR_HEADER;
          end else begin
            cls     = CLS_HNAME;
            line_st = LINE_MID;
            first   = bump();
          end
        end
        P_BODY: begin
          cls   = CLS_BODY;
          first = bump();
        end
        default: ;
      endcase

      if (fail != ERR_NONE) begin
        err   = fail;
        ph    = P_FAILED;
        cls   = CLS_SEP;
        first = 1'b0;
      end
      // request cut short before the body
      if (last && ph != P_BODY && ph != P_FAILED) begin
        case (ph)
          P_METHOD:        err = ERR_METHOD;
          P_PATH, P_QUERY: err = ERR_URL;
          P_PROTO:         err = ERR_PROTO;
          default:         err = ERR_HEADER;
        endcase
        ph = P_FAILED;
      end

      r.ext_status = EXT_UNKNOWN;
      if ((ph inside {P_QUERY, P_PROTO, P_HEADER, P_BODY}) ||
          (ph == P_FAILED && err >= ERR_PROTO)) begin
        if (slash_last) begin
          r.ext_status = EXT_DIR;
        end else if (dot_seen) begin
          r.ext_status = EXT_PRESENT;
          r.ext_length = ext_cnt;
        end else begin
          r.ext_status = EXT_NONE;
        end
      end
      r.out_byte     = b;
      r.field_class  = cls;
      r.field_first  = first;
      r.method_code  = meth;
      r.proto_code   = prot;
      r.header_index = hidx;
      r.error_code   = err;
      r.request_done = (ph == P_FAILED) || last;
      expected_tags.push_back(r);
      if (last) restart();
    endfunction

    function string describe(tag_result_t t);
      return $sformatf({"byte=%02h class=%0d first=%0d meth=%0d proto=%0d hidx=%0d ",
                        "ext=%0d extlen=%0d err=%0d done=%0d"},
                       t.out_byte, t.field_class, t.field_first, t.method_code,
                       t.proto_code, t.header_index, t.ext_status, t.ext_length,
                       t.error_code, t.request_done);
    endfunction

    function void check_result(tag_result_t got);
      tag_result_t want;
      string       bad;
      results++;
      if (expected_tags.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected result %0d: %s", results, describe(got));
        return;
      end
      want = expected_tags.pop_front();
      bad  = "";
      if (got.out_byte !== want.out_byte)         bad = {bad, " out_byte"};
      if (got.field_class !== want.field_class)   bad = {bad, " field_class"};
      if (got.field_first !== want.field_first)   bad = {bad, " field_first"};
      if (got.method_code !== want.method_code)   bad = {bad, " method_code"};
      if (got.proto_code !== want.proto_code)     bad = {bad, " proto_code"};
      if (got.header_index !== want.header_index) bad = {bad, " header_index"};
      if (got.ext_status !== want.ext_status)     bad = {bad, " ext_status"};
      if (got.ext_length !== want.ext_length)     bad = {bad, " ext_length"};
      if (got.error_code !== want.error_code)     bad = {bad, " error_code"};
      if (got.request_done !== want.request_done) bad = {bad, " request_done"};
      if (bad != "") begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch on result %0d:%s", results, bad);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end
    endfunction

    function int outstanding();
      return expected_tags.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'd0;

  tag_scoreboard sb;
  req_item_t     send_q[$];
  logic [7:0]    req_bytes[$];
  int            tx_gap_pct = 22;
  int            rx_gap_pct = 84;
  bit            hold_request = 1'b0;
  bit            hold_done = 1'b0;
  int            hold_left = 0;
  int            quiet_cycles = 0;

  http_request_tokenizer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // request bytes in; valid is only dropped or moved on after a transfer
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata, s_axis_tlast);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_q.size() != 0 && $urandom_range(0, 99) >= tx_gap_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= send_q[0].data;
          s_axis_tlast  <= send_q[0].last;
          void'(send_q.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // tagged bytes out, with one long hold-off to back the block up
  always @(posedge clk) begin : take_tags
    tag_result_t got;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[7:0], m_axis_tuser[2:0], m_axis_tuser[3], m_axis_tdata[8],
               m_axis_tdata[10:9], m_axis_tdata[18:11], m_axis_tdata[20:19],
               m_axis_tdata[28:21], m_axis_tdata[31:29], m_axis_tlast};
        sb.check_result(got);
      end
      if (hold_request && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_gap_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] any_byte_but(input logic [7:0] a, b, c, d);
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == a || v == b || v == c || v == d);
    return v;
  endfunction

  // octal 015 and 012 below are cr and lf
  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) req_bytes.push_back(s[i]);
  endfunction

  // move the request being built onto the send queue, tlast on its final byte
  function automatic void commit_request();
    if (req_bytes.size() == 0) req_bytes.push_back(8'($urandom_range(0, 255)));
    for (int i = 0; i < req_bytes.size(); i++)
      send_q.push_back('{data: req_bytes[i], last: (i == req_bytes.size() - 1)});
    req_bytes.delete();
  endfunction

  task automatic queue_directed();
    // well-formed: directory, extension, bare lf in value, dot at end, empty path, no slash
    add_text("GET / HTTP/1.1\015\012Host: x\015\012\015\012");
    commit_request();
    add_text("POST /a/b.html?x=1&y HTTP/2\015\012A: b\015\012C: \015\012\015\012xy");
    req_bytes.push_back(CH_NUL);
    req_bytes.push_back(8'hFF);
    commit_request();
    add_text("GET /dir/file HTTP/3\015\012k: v\nw\015\012\015\012");
    commit_request();
    add_text("GET /x. HTTP/1.1\015\012:  \015\012\015\012");
    commit_request();
    add_text("GET  HTTP/1.1\015\012h: 1\015\012\015\012");
    commit_request();
    add_text("POST a.txt? HTTP/2\015\012h: 1\015\012B: 2\015\012\015\012");
    req_bytes.push_back(8'h80);
    commit_request();
    // extension longer than the counter can hold
    add_text("GET /a.");
    repeat (300) add_text("x");
    add_text(" HTTP/1.1\015\012h: 1\015\012\015\012");
    commit_request();
    // bad method, then a request cut short in every part
    add_text("GEX / HTTP/1.1\015\012");
    commit_request();
    add_text("GETX");
    commit_request();
    add_text("POS");
    commit_request();
    add_text("GET /ab");
    commit_request();
    add_text("GET /?q");
    commit_request();
    add_text("GET / HTTP/1");
    commit_request();
    add_text("GET / HTTP/1.1\015\012A: b");
    commit_request();
    // nul before the body
    add_text("GET /a");
    req_bytes.push_back(CH_NUL);
    add_text(" x");
    commit_request();
    add_text("GET /?");
    req_bytes.push_back(CH_NUL);
    commit_request();
    add_text("GET / HTTP/1.1\015\012A");
    req_bytes.push_back(CH_NUL);
    commit_request();
    add_text("GET / HTTP/1.1\015\012A: ");
    req_bytes.push_back(CH_NUL);
    add_text("\015\012\015\012");
    commit_request();
    // protocol errors
    add_text("GET / HTTP/4\015\012");
    commit_request();
    add_text("GET / HTTP/1.1\015X\012");
    commit_request();
    // colon with no space, lone cr, no header line, blank line broken
    add_text("GET / HTTP/1.1\015\012A:b\015\012\015\012");
    commit_request();
    add_text("GET / HTTP/1.1\015\012A: b\015X\015\012\015\012");
    commit_request();
    add_text("GET / HTTP/1.1\015\012\015\012");
    commit_request();
    add_text("POST /up HTTP/3\015\012A: 1\015\012\015X");
    commit_request();
  endtask

  // more header lines than the reset limit of 64 allows
  task automatic queue_header_flood();
    add_text("GET /index.html HTTP/1.1\015\012");
    repeat (66) add_text("a: \015\012");
    add_text("\015\012done");
    commit_request();
  endtask

  // mostly well-formed requests with random content, some broken, some noise
  task automatic queue_random_bytes(input int budget);
    int added;
    int kind;
    int n;
    added = 0;
    while (added < budget) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        repeat ($urandom_range(1, 12)) req_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        add_text(method_names[$urandom_range(0, 1)]);
        req_bytes.push_back(CH_SPACE);
        repeat ($urandom_range(0, 10)) begin
          case ($urandom_range(0, 9))
            0, 1:       req_bytes.push_back(CH_SLASH);
            2:          req_bytes.push_back(CH_DOT);
            3, 4, 5, 6: req_bytes.push_back(8'($urandom_range(97, 122)));
            default:    req_bytes.push_back(any_byte_but(CH_SPACE, CH_QMARK, CH_NUL, CH_NUL));
          endcase
        end
        if ($urandom_range(0, 3) == 0) begin
          req_bytes.push_back(CH_QMARK);
          repeat ($urandom_range(0, 6))
            req_bytes.push_back(any_byte_but(CH_SPACE, CH_NUL, CH_NUL, CH_NUL));
        end
        req_bytes.push_back(CH_SPACE);
        add_text(proto_names[$urandom_range(0, 2)]);
        add_text("\015\012");
        repeat ($urandom_range(1, 6)) begin
          repeat ($urandom_range(0, 5))
            req_bytes.push_back(($urandom_range(0, 3) == 0) ?
                                any_byte_but(CH_COLON, CH_CR, CH_LF, CH_NUL) :
                                8'($urandom_range(97, 122)));
          add_text(": ");
          repeat ($urandom_range(0, 6))
            req_bytes.push_back(any_byte_but(CH_CR, CH_NUL, CH_CR, CH_NUL));
          add_text("\015\012");
        end
        add_text("\015\012");
        repeat ($urandom_range(0, 8)) req_bytes.push_back(8'($urandom_range(0, 255)));
        if (kind < 20) begin
          if ($urandom_range(0, 1) == 1) begin
            req_bytes[$urandom_range(0, req_bytes.size() - 1)] = 8'($urandom_range(0, 255));
          end else begin
            n = $urandom_range(1, req_bytes.size());
            repeat (req_bytes.size() - n) void'(req_bytes.pop_back());
          end
        end
      end
      added += req_bytes.size();
      commit_request();
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (send_q.size() != 0 || s_axis_tvalid || sb.outstanding() != 0);
  endtask

  task automatic write_max_lines(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.max_lines = value;
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset limit of 64, receiver mostly stalled
    queue_directed();
    queue_header_flood();
    queue_random_bytes(120);
    wait_drained();

    write_max_lines(8'd1);
    queue_random_bytes(100);
    wait_drained();

    // sender mostly idle
    tx_gap_pct = 84;
    rx_gap_pct = 22;
    write_max_lines(8'd255);
    queue_random_bytes(100);
    wait_drained();

    // a limit of zero rejects the first header line
    write_max_lines(8'd0);
    queue_random_bytes(60);
    wait_drained();

    // full rate both ways, with one long receiver hold-off
    tx_gap_pct = 0;
    rx_gap_pct = 0;
    write_max_lines(8'($urandom_range(2, 8)));
    queue_random_bytes(120);
    hold_request = 1'b1;
    wait_drained();

    repeat (10) @(posedge clk);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== http_request_tokenizer.f =====
rtl/core/htok_pkg.sv
rtl/core/htok_parser.sv
rtl/core/http_request_tokenizer.sv
tb/sv/testbench.sv
